// ===== sv/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 adjugate matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int N_ELEM         = 9;

	// minor k = e[t0]*e[t1] - e[t2]*e[t3], checkerboard signs folded in
	localparam logic [3:0] COF_TERMS [N_ELEM][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
	};

endpackage

// ===== sv/matrix3_inverse_core.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// 3x3 signed fixed-point matrix inverse by the adjugate, fully pipelined.
// ----------------------------------------------------------------------------
// Input beat on s_*: nine elements a00..a22 in tdata. Output beat on m_*:
// inverse inv00..inv22 and the determinant in tdata, singular and saturated
// in tuser. Elements are signed with FRAC_BITS fraction bits.
// Pipeline stages: seven for products, cofactors, determinant and operand
// preparation, one restoring division stage per quotient bit shared by the
// nine lanes, one output stage.
// Throughput is one matrix per cycle while m_tready is held high.
// Every stage has its own valid bit and loads when empty or when the stage
// after it moves, so bubbles close up and a stalled m_tready holds results in
// place; s_tready drops only once the whole pipeline is full.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
// A zero determinant gives a zero matrix with singular set.
// ----------------------------------------------------------------------------
module matrix3_inverse_core #(
	parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// a00 a01 a02 a10 a11 a12 a20 a21 a22
	input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// inv00 inv01 inv02 inv10 inv11 inv12 inv20 inv21 inv22 determinant
	output logic [((10*DATA_WIDTH+7)/8)*8-1:0]       m_tdata,
	// singular saturated
	output logic [1:0]                               m_tuser
);
	localparam int DW  = DATA_WIDTH;
	localparam int NE  = m3i_pkg::N_ELEM;
	localparam int CW  = 2 * DW + 1;
	localparam int DTW = 3 * DW + 3;
	localparam int NMW = CW + 2 * FRAC_BITS;
	localparam int RW  = DTW + DW;
	localparam int XW  = (NMW > RW) ? NMW : RW;
	localparam int NS  = DW + 8;
	localparam int ODW = ((10*DW+7)/8)*8;

	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !v_q[NS-1] || m_tready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = v_q[NS-1];

	// stages 1-2
	logic [NE-1:0][DW-1:0] elem;
	logic [2:0][DW-1:0]    row0_s2;
	logic [NE-1:0][CW-1:0] cof_s2;

	always_comb begin
		for (int k = 0; k < NE; k++) begin
			elem[k] = s_tdata[k*DW +: DW];
		end
	end

	m3i_cofactor #(.DATA_WIDTH(DW)) u_cof (
		.clk     (clk),
		.en1     (en[0]),
		.en2     (en[1]),
		.elem    (elem),
		.row0_s2 (row0_s2),
		.cof_s2  (cof_s2)
	);

	// stages 3-5
	logic [NE-1:0][CW-1:0] cof_s5;
	logic [DTW-1:0]        det_s5;

	m3i_det #(.DATA_WIDTH(DW)) u_det (
		.clk    (clk),
		.en3    (en[2]),
		.en4    (en[3]),
		.en5    (en[4]),
		.row0   (row0_s2),
		.cof    (cof_s2),
		.cof_s5 (cof_s5),
		.det_s5 (det_s5)
	);

	// stage 6: magnitudes and signs
	logic [DTW-1:0]         det_mag_s6;
	logic [DTW-1:0]         det_sh_s6;
	logic                   det_neg_s6;
	logic                   sing_s6;
	logic [NE-1:0][NMW-1:0] num_s6;
	logic [NE-1:0]          sgn_s6;
	logic [DTW-1:0]         det_abs;
	logic [NE-1:0][CW-1:0]  cof_abs;

	always_comb begin
		det_abs = det_s5[DTW-1] ? DTW'(-det_s5) : det_s5;
		for (int k = 0; k < NE; k++) begin
			cof_abs[k] = cof_s5[k][CW-1] ? CW'(-cof_s5[k]) : cof_s5[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			det_mag_s6 <= det_abs;
			det_sh_s6  <= det_abs >> (2 * FRAC_BITS);
			det_neg_s6 <= det_s5[DTW-1];
			sing_s6    <= (det_s5 == '0);
			for (int k = 0; k < NE; k++) begin
				num_s6[k] <= NMW'(cof_abs[k]) << (2 * FRAC_BITS);
				sgn_s6[k] <= cof_s5[k][CW-1] ^ det_s5[DTW-1];
			end
		end
	end

	// stage 7: overflow check and determinant output
	logic [DTW-1:0] det_lim;
	logic           det_nz;
	logic           det_over;

	assign det_nz   = (det_sh_s6 != '0);
	assign det_lim  = (det_neg_s6 && det_nz) ? (DTW'(1) << (DW - 1))
	                                         : ((DTW'(1) << (DW - 1)) - DTW'(1));
	assign det_over = det_sh_s6 > det_lim;

	logic [DW:0][DTW-1:0]         dm_c;
	logic [DW:0][NE-1:0][RW-1:0]  rem_c;
	logic [DW:0][NE-1:0][DW-1:0]  quo_c;
	logic [DW:0][NE-1:0]          ovf_c;
	logic [DW:0][NE-1:0]          sgn_c;
	logic [DW:0]                  sing_c;
	logic [DW:0]                  dsat_c;
	logic [DW:0][DW-1:0]          dval_c;
	logic [DW-1:0]                dmag_out;

	assign dmag_out = det_over ? DW'(det_lim) : DW'(det_sh_s6);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			dm_c[0]   <= det_mag_s6;
			sing_c[0] <= sing_s6;
			sgn_c[0]  <= sgn_s6;
			dsat_c[0] <= det_over;
			dval_c[0] <= (det_neg_s6 && det_nz) ? DW'(-dmag_out) : dmag_out;
			for (int k = 0; k < NE; k++) begin
				ovf_c[0][k] <= XW'(num_s6[k]) >= (XW'(det_mag_s6) << DW);
				rem_c[0][k] <= RW'(num_s6[k]);
				quo_c[0][k] <= '0;
			end
		end
	end

	// division stages
	for (genvar i = 0; i < DW; i++) begin : g_div
		m3i_div_stage #(.DATA_WIDTH(DW), .BIT_POS(DW - 1 - i)) u_stage (
			.clk       (clk),
			.en        (en[7+i]),
			.det_mag   (dm_c[i]),
			.rem       (rem_c[i]),
			.quo       (quo_c[i]),
			.det_mag_q (dm_c[i+1]),
			.rem_q     (rem_c[i+1]),
			.quo_q     (quo_c[i+1])
		);

		always_ff @(posedge clk) begin
			if (en[7+i]) begin
				ovf_c[i+1]  <= ovf_c[i];
				sgn_c[i+1]  <= sgn_c[i];
				sing_c[i+1] <= sing_c[i];
				dsat_c[i+1] <= dsat_c[i];
				dval_c[i+1] <= dval_c[i];
			end
		end
	end

	// output stage: sign, saturation, singular override
	logic [NE-1:0][DW-1:0] inv_val;
	logic [NE-1:0]         inv_over;
	logic [NE-1:0][DW-1:0] lim;
	logic [NE-1:0][DW-1:0] qsat;
	logic [NE-1:0]         qneg;
	logic [ODW-1:0]        tdata_s;

	always_comb begin
		for (int k = 0; k < NE; k++) begin
			qneg[k]     = sgn_c[DW][k] && (quo_c[DW][k] != '0 || ovf_c[DW][k]);
			lim[k]      = qneg[k] ? (DW'(1) << (DW - 1)) : ((DW'(1) << (DW - 1)) - DW'(1));
			inv_over[k] = ovf_c[DW][k] || (quo_c[DW][k] > lim[k]);
			qsat[k]     = inv_over[k] ? lim[k] : quo_c[DW][k];
			inv_val[k]  = qneg[k] ? DW'(-qsat[k]) : qsat[k];
		end
		tdata_s = '0;
		if (!sing_c[DW]) begin
			for (int k = 0; k < NE; k++) begin
				tdata_s[k*DW +: DW] = inv_val[k];
			end
			tdata_s[NE*DW +: DW] = dval_c[DW];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			m_tdata    <= tdata_s;
			m_tuser[0] <= sing_c[DW];
			m_tuser[1] <= !sing_c[DW] && (dsat_c[DW] || (inv_over != '0));
		end
	end

endmodule

// ===== sv/m3i_cofactor.sv =====
// ----------------------------------------------------------------------------
// m3i_cofactor
// Two stages: the eighteen element products, then the nine signed cofactors.
// ----------------------------------------------------------------------------
module m3i_cofactor #(
	parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
) (
	input  logic                                             clk,
	input  logic                                             en1,
	input  logic                                             en2,
	input  logic [m3i_pkg::N_ELEM-1:0][DATA_WIDTH-1:0]       elem,
	output logic [2:0][DATA_WIDTH-1:0]                       row0_s2,
	output logic [m3i_pkg::N_ELEM-1:0][2*DATA_WIDTH:0]       cof_s2
);
	localparam int PW = 2 * DATA_WIDTH;
	localparam int CW = 2 * DATA_WIDTH + 1;

	logic [m3i_pkg::N_ELEM-1:0][PW-1:0] p_s1;
	logic [m3i_pkg::N_ELEM-1:0][PW-1:0] q_s1;
	logic [2:0][DATA_WIDTH-1:0]         row0_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
				p_s1[k] <= PW'($signed(elem[m3i_pkg::COF_TERMS[k][0]]))
					* PW'($signed(elem[m3i_pkg::COF_TERMS[k][1]]));
				q_s1[k] <= PW'($signed(elem[m3i_pkg::COF_TERMS[k][2]]))
					* PW'($signed(elem[m3i_pkg::COF_TERMS[k][3]]));
			end
			row0_s1 <= elem[2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
				cof_s2[k] <= CW'($signed(p_s1[k])) - CW'($signed(q_s1[k]));
			end
			row0_s2 <= row0_s1;
		end
	end

endmodule

// ===== sv/m3i_det.sv =====
// ----------------------------------------------------------------------------
// m3i_det
// Three stages: split partial products of row 0 by its cofactors, term
// assembly, then the determinant sum.
// ----------------------------------------------------------------------------
module m3i_det #(
	parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        en3,
	input  logic                                        en4,
	input  logic                                        en5,
	input  logic [2:0][DATA_WIDTH-1:0]                  row0,
	input  logic [m3i_pkg::N_ELEM-1:0][2*DATA_WIDTH:0]  cof,
	output logic [m3i_pkg::N_ELEM-1:0][2*DATA_WIDTH:0]  cof_s5,
	output logic [3*DATA_WIDTH+2:0]                     det_s5
);
	localparam int DW  = DATA_WIDTH;
	localparam int PPW = 2 * DW + 1;
	localparam int DTW = 3 * DW + 3;

	logic [2:0][PPW-1:0]                     pl_s3;
	logic [2:0][PPW-1:0]                     ph_s3;
	logic [2:0][DTW-1:0]                     term_s4;
	logic [m3i_pkg::N_ELEM-1:0][2*DW:0]      cof_s3;
	logic [m3i_pkg::N_ELEM-1:0][2*DW:0]      cof_s4;

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int j = 0; j < 3; j++) begin
				pl_s3[j] <= PPW'($signed(row0[j]))
					* PPW'($signed({1'b0, cof[3*j][DW-1:0]}));
				ph_s3[j] <= PPW'($signed(row0[j])) * PPW'($signed(cof[3*j][2*DW:DW]));
			end
			cof_s3 <= cof;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int j = 0; j < 3; j++) begin
				term_s4[j] <= (DTW'($signed(ph_s3[j])) <<< DW) + DTW'($signed(pl_s3[j]));
			end
			cof_s4 <= cof_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			cof_s5 <= cof_s4;
		end
	end

endmodule

// ===== sv/m3i_div_stage.sv =====
// ----------------------------------------------------------------------------
// m3i_div_stage
// One restoring division step for all nine lanes: quotient bit BIT_POS.
// ----------------------------------------------------------------------------
module m3i_div_stage #(
	parameter int DATA_WIDTH = m3i_pkg::DATA_WIDTH_DEF,
	parameter int BIT_POS    = 0
) (
	input  logic                                          clk,
	input  logic                                          en,
	input  logic [3*DATA_WIDTH+2:0]                       det_mag,
	input  logic [m3i_pkg::N_ELEM-1:0][4*DATA_WIDTH+2:0]  rem,
	input  logic [m3i_pkg::N_ELEM-1:0][DATA_WIDTH-1:0]    quo,
	output logic [3*DATA_WIDTH+2:0]                       det_mag_q,
	output logic [m3i_pkg::N_ELEM-1:0][4*DATA_WIDTH+2:0]  rem_q,
	output logic [m3i_pkg::N_ELEM-1:0][DATA_WIDTH-1:0]    quo_q
);
	localparam int RW = 4 * DATA_WIDTH + 3;

	logic [RW-1:0] dsh;

	assign dsh = RW'(det_mag) << BIT_POS;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
				if (rem[k] >= dsh) begin
					rem_q[k] <= rem[k] - dsh;
					quo_q[k] <= quo[k] | (DATA_WIDTH'(1) << BIT_POS);
				end else begin
					rem_q[k] <= rem[k];
					quo_q[k] <= quo[k];
				end
			end
			det_mag_q <= det_mag;
		end
	end

endmodule

// ===== bench/matrix3_inverse_core_tb.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_core_tb
// Self-checking bench for the 3x3 adjugate inverse pipeline.
// Drives directed matrices (identity, extremes, singular, tiny and saturating
// determinants), then random matrices of several kinds. Each accepted beat is
// predicted with exact wide arithmetic. Results are compared in order, with
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module matrix3_inverse_core_tb;

	localparam int DW        = 32;
	localparam int N_RANDOM  = 1200;
	localparam int CYCLE_CAP = 400000;

	typedef logic signed [191:0] wide_t;
	typedef logic signed [DW-1:0] elem_t;

	typedef struct packed {
		logic [319:0] body;
		logic [1:0]   flags;
	} inv_res_t;

	typedef struct {
		bit           fixed;
		logic [287:0] mat;
		inv_res_t     res;
	} stim_row_t;

	// cofactor k = e[i0]*e[i1] - e[i2]*e[i3], laid out as inverse index
	localparam int MINOR_IDX [9][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [287:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [319:0] m_tdata;
	logic [1:0]   m_tuser;

	inv_res_t     inverse_q [$];
	int           n_errors = 0;
	int           n_sent = 0;
	int           n_checked = 0;
	int           n_singular = 0;
	int           n_clipped = 0;
	int           n_cycles = 0;

	matrix3_inverse_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [287:0] mat9(elem_t e0, elem_t e1, elem_t e2, elem_t e3,
			elem_t e4, elem_t e5, elem_t e6, elem_t e7, elem_t e8);
		return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
	endfunction

	function automatic elem_t clip32(wide_t v, inout bit clipped);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (DW - 1)) - 1;
		lo = -(wide_t'(1) <<< (DW - 1));
		if (v > hi) begin
			clipped = 1'b1;
			return hi[DW-1:0];
		end
		if (v < lo) begin
			clipped = 1'b1;
			return lo[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	function automatic inv_res_t invert_matrix(logic [287:0] mat);
		wide_t    x [9];
		wide_t    cof [9];
		wide_t    det;
		wide_t    num;
		bit       clipped;
		inv_res_t r;
		clipped = 1'b0;
		for (int k = 0; k < 9; k++) begin
			x[k] = elem_t'(mat[k*DW +: DW]);
		end
		for (int k = 0; k < 9; k++) begin
			cof[k] = x[MINOR_IDX[k][0]] * x[MINOR_IDX[k][1]]
				- x[MINOR_IDX[k][2]] * x[MINOR_IDX[k][3]];
		end
		det = x[0] * cof[0] + x[1] * cof[3] + x[2] * cof[6];
		r.body = '0;
		if (det == 0) begin
			r.flags = 2'b01;
			return r;
		end
		for (int k = 0; k < 9; k++) begin
			num = cof[k] <<< 32;
			r.body[k*DW +: DW] = clip32(num / det, clipped);
		end
		r.body[9*DW +: DW] = clip32(det / (wide_t'(1) <<< 32), clipped);
		r.flags = {clipped, 1'b0};
		return r;
	endfunction

	function automatic elem_t rand_elem(int kind);
		case (kind)
			0: return elem_t'($urandom);
			1: return elem_t'($urandom_range(0, 1 << 20)) - (1 << 19);
			default: begin
				case ($urandom_range(3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return '0;
					default: return elem_t'($urandom);
				endcase
			end
		endcase
	endfunction

	task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
		n_errors++;
		$display("[%0t] beat %0d %s[%0d]: got %h want %h", $time, n_checked, what, idx,
			got, want);
	endtask

	task automatic send_matrix(logic [287:0] mat);
		int gap;
		gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= mat;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// scoreboard: predict on input beats, check on output beats
	always @(posedge clk) begin
		inv_res_t want;
		if (s_tvalid && s_tready) begin
			inverse_q.push_back(invert_matrix(s_tdata));
			n_sent++;
		end
		if (m_tvalid && m_tready) begin
			if (inverse_q.size() == 0) begin
				n_errors++;
				$display("[%0t] unexpected output beat", $time);
			end else begin
				want = inverse_q.pop_front();
				for (int k = 0; k < 10; k++) begin
					if (m_tdata[k*DW +: DW] !== want.body[k*DW +: DW])
						report(k == 9 ? "det" : "inv", k, m_tdata[k*DW +: DW],
							want.body[k*DW +: DW]);
				end
				for (int k = 0; k < 2; k++) begin
					if (m_tuser[k] !== want.flags[k])
						report("tuser", k, m_tuser[k], want.flags[k]);
				end
				n_singular += want.flags[0];
				n_clipped  += want.flags[1];
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// output side: random backpressure plus one long hold-off
	initial begin
		int  gap;
		bit  held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && n_sent >= 400) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(17);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		stim_row_t    rows [13];
		elem_t        e [9];
		int           kind;
		inv_res_t     fix;

		fix.flags = 2'b00;
		fix.body = '0;
		fix.body[0*DW +: DW] = 32'h10000;
		fix.body[4*DW +: DW] = 32'h10000;
		fix.body[8*DW +: DW] = 32'h10000;
		fix.body[9*DW +: DW] = 32'h10000;
		rows[0] = '{1'b1, mat9(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000), fix};
		fix.body = '0;
		fix.flags = 2'b01;
		rows[1] = '{1'b1, '0, fix};
		rows[2] = '{1'b1, {9{32'h7fffffff}}, fix};
		rows[3] = '{1'b1, {9{32'h80000000}}, fix};
		rows[4] = '{1'b1, mat9(32'h10000, 32'h20000, 32'h30000, 32'h20000, 32'h40000,
			32'h60000, 32'h5, 32'h7, 32'h9), fix};
		rows[4].mat[3*DW +: 3*DW] = rows[4].mat[0 +: 3*DW];
		fix.flags = 2'b00;
		fix.body[0*DW +: DW] = 32'h8000;
		fix.body[4*DW +: DW] = 32'h8000;
		fix.body[8*DW +: DW] = 32'h8000;
		fix.body[9*DW +: DW] = 32'h80000;
		rows[5] = '{1'b1, mat9(32'h20000, 0, 0, 0, 32'h20000, 0, 0, 0, 32'h20000), fix};
		fix.body[0*DW +: DW] = 32'hffff0000;
		fix.body[4*DW +: DW] = 32'hffff0000;
		fix.body[8*DW +: DW] = 32'hffff0000;
		fix.body[9*DW +: DW] = 32'hffff0000;
		rows[6] = '{1'b1, mat9(32'hffff0000, 0, 0, 0, 32'hffff0000, 0, 0, 0,
			32'hffff0000), fix};
		rows[7] = '{1'b0, mat9(32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0,
			32'h7fffffff), fix};
		rows[8] = '{1'b0, mat9(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0,
			32'h80000000), fix};
		rows[9] = '{1'b0, mat9(1, 0, 0, 0, 1, 0, 0, 0, 1), fix};
		rows[10] = '{1'b0, mat9(0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0), fix};
		rows[11] = '{1'b0, mat9(32'h7fffffff, 32'h80000000, 1, 32'hffffffff, 32'h7fffffff,
			0, 32'h80000000, 32'h12345678, 32'h7fffffff), fix};
		rows[12] = '{1'b0, mat9(32'h18000, 32'hfffe8000, 32'h4000, 32'h3000, 32'h29000,
			32'hfff00000, 32'h777, 32'hffffff01, 32'h0c000), fix};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].fixed && invert_matrix(rows[i].mat) != rows[i].res) begin
				n_errors++;
				$display("directed row %0d disagrees with hand value", i);
			end
			send_matrix(rows[i].mat);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(9);
			for (int k = 0; k < 9; k++)
				e[k] = rand_elem(kind <= 2 ? 0 : kind <= 6 ? 1 : 2);
			if (kind == 7) begin
				e[6] = e[0];
				e[7] = e[1];
				e[8] = e[2];
			end
			if (kind == 8) begin
				e[0] = 32'h80000 + e[0];
				e[4] = 32'h80000 + e[4];
				e[8] = 32'h80000 + e[8];
			end
			send_matrix(mat9(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]));
		end
		s_tvalid <= 1'b0;

		while (inverse_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d matrices accepted, %0d results checked", n_sent, n_checked);
		$display("%0d singular, %0d clipped, %0d errors", n_singular, n_clipped, n_errors);
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
